// ===== design/nirf_pkg.sv =====
// Package for the NEC infrared frame decoder.
// Holds the configuration register set, register indexes and reset values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nirf_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 40;

  localparam logic [CfgIdxW-1:0] CFG_CONFIRM_DELAY     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_LEADER_LOW_LIMIT  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_LEADER_HIGH_LIMIT = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_BIT_LOW_LIMIT     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_HIGH_ABORT_LIMIT  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_ONE_THRESHOLD     = 3'd5;

  localparam logic [9:0] RST_CONFIRM_DELAY     = 10'd70;
  localparam logic [9:0] RST_LEADER_LOW_LIMIT  = 10'd1000;
  localparam logic [9:0] RST_LEADER_HIGH_LIMIT = 10'd500;
  localparam logic [7:0] RST_BIT_LOW_LIMIT     = 8'd60;
  localparam logic [5:0] RST_HIGH_ABORT_LIMIT  = 6'd30;
  localparam logic [5:0] RST_ONE_THRESHOLD     = 6'd8;

  typedef struct packed {
    logic [9:0] confirm_delay;
    logic [9:0] leader_low_limit;
    logic [9:0] leader_high_limit;
    logic [7:0] bit_low_limit;
    logic [5:0] high_abort_limit;
    logic [5:0] one_threshold;
  } cfg_t;

endpackage

`default_nettype wire

// ===== design/nec_ir_frame_decoder.sv =====
// NEC infrared frame decoder, top level: stream ports, configuration
// registers, input register and result register. Depends on nirf_pkg, nirf_core.
// Data path: an accepted sample is held in the input register, and its frame is registered in the result register.
// Throughput: one sample per cycle; the input stalls only while a held
// result is not taken and the next sample is waiting in the input register.
// Reset: configuration takes its reset values, the decoder goes idle.
`timescale 1ns / 1ps
`default_nettype none

module nec_ir_frame_decoder (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [nirf_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [nirf_pkg::CfgDataW-1:0]   cfg_data_i,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // ir_level [0], zero fill [7:1]
  input  wire logic [nirf_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // address [7:0], address_inverse [15:8], command [23:16],
  // command_inverse [31:24], check_ok [32], zero fill [39:33]
  output logic [nirf_pkg::OutDataW-1:0]        m_axis_tdata
);

  nirf_pkg::cfg_t cfg_q;
  logic           in_valid_q;
  logic           level_q;
  logic           out_valid_q;
  logic [nirf_pkg::OutDataW-1:0] out_data_q;
  logic           advance;
  logic           res_valid;
  logic [31:0]    frame;
  logic           check_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.confirm_delay     <= nirf_pkg::RST_CONFIRM_DELAY;
      cfg_q.leader_low_limit  <= nirf_pkg::RST_LEADER_LOW_LIMIT;
      cfg_q.leader_high_limit <= nirf_pkg::RST_LEADER_HIGH_LIMIT;
      cfg_q.bit_low_limit     <= nirf_pkg::RST_BIT_LOW_LIMIT;
      cfg_q.high_abort_limit  <= nirf_pkg::RST_HIGH_ABORT_LIMIT;
      cfg_q.one_threshold     <= nirf_pkg::RST_ONE_THRESHOLD;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        nirf_pkg::CFG_CONFIRM_DELAY:     cfg_q.confirm_delay     <= cfg_data_i;
        nirf_pkg::CFG_LEADER_LOW_LIMIT:  cfg_q.leader_low_limit  <= cfg_data_i;
        nirf_pkg::CFG_LEADER_HIGH_LIMIT: cfg_q.leader_high_limit <= cfg_data_i;
        nirf_pkg::CFG_BIT_LOW_LIMIT:     cfg_q.bit_low_limit     <= cfg_data_i[7:0];
        nirf_pkg::CFG_HIGH_ABORT_LIMIT:  cfg_q.high_abort_limit  <= cfg_data_i[5:0];
        nirf_pkg::CFG_ONE_THRESHOLD:     cfg_q.one_threshold     <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      level_q <= s_axis_tdata[0];
    end
  end

  nirf_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .step_i      (advance),
    .level_i     (level_q),
    .res_valid_o (res_valid),
    .frame_o     (frame)
  );

  assign check_ok = (frame[23:16] == ~frame[31:24]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_data_q <= {7'd0, check_ok, frame};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

// ===== design/nirf_core.sv =====
// Frame state machine of the NEC infrared decoder: one line sample per step.
// Holds phase, timers, bit counter and the frame register.
// Depends on nirf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nirf_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire nirf_pkg::cfg_t cfg_i,
  input  wire logic          step_i,
  input  wire logic          level_i,
  output logic               res_valid_o,
  output logic [31:0]        frame_o
);

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_CONFIRM   = 3'd1,
    PH_LEAD_LOW  = 3'd2,
    PH_LEAD_HIGH = 3'd3,
    PH_BIT_LOW   = 3'd4,
    PH_BIT_HIGH  = 3'd5
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [9:0]  wait_q, wait_d;
  logic [5:0]  high_q, high_d;
  logic [4:0]  bit_idx_q, bit_idx_d;
  logic [31:0] frame_q, frame_d;
  logic        last_level_q;
  logic        edge_fall;
  logic        done;

  assign edge_fall = last_level_q & ~level_i;

  // A phase that ends hands the same sample to the next one; four steps
  // cover the longest such chain.
  always_comb begin
    phase_d     = phase_q;
    wait_d      = wait_q;
    high_d      = high_q;
    bit_idx_d   = bit_idx_q;
    frame_d     = frame_q;
    res_valid_o = 1'b0;
    done        = 1'b0;
    for (int s = 0; s < 4; s++) begin
      if (!done) begin
        case (phase_d)
          PH_CONFIRM: begin
            if (wait_d < cfg_i.confirm_delay) begin
              wait_d = wait_d + 10'd1;
              done   = 1'b1;
            end else if (!level_i) begin
              phase_d = PH_LEAD_LOW;
              wait_d  = cfg_i.leader_low_limit;
            end else begin
              phase_d = PH_IDLE;
              done    = 1'b1;
            end
          end
          PH_LEAD_LOW: begin
            if (!level_i && wait_d != 10'd0) begin
              wait_d = wait_d - 10'd1;
              done   = 1'b1;
            end else if (level_i) begin
              phase_d = PH_LEAD_HIGH;
              wait_d  = cfg_i.leader_high_limit;
            end else begin
              phase_d = PH_IDLE;
              done    = 1'b1;
            end
          end
          PH_LEAD_HIGH: begin
            if (level_i && wait_d != 10'd0) begin
              wait_d = wait_d - 10'd1;
              done   = 1'b1;
            end else begin
              phase_d = PH_BIT_LOW;
              wait_d  = {2'b00, cfg_i.bit_low_limit};
              high_d  = 6'd0;
            end
          end
          PH_BIT_LOW: begin
            if (!level_i && wait_d != 10'd0) begin
              wait_d = wait_d - 10'd1;
              done   = 1'b1;
            end else begin
              phase_d = PH_BIT_HIGH;
              high_d  = 6'd0;
            end
          end
          PH_BIT_HIGH: begin
            done = 1'b1;
            if (level_i) begin
              if (high_d >= cfg_i.high_abort_limit) begin
                phase_d = PH_IDLE;
                high_d  = 6'd0;
              end else begin
                high_d = high_d + 6'd1;
              end
            end else begin
              frame_d[bit_idx_d] = (high_d >= cfg_i.one_threshold);
              high_d = 6'd0;
              if (bit_idx_d == 5'd31) begin
                res_valid_o = 1'b1;
                bit_idx_d   = 5'd0;
                phase_d     = PH_IDLE;
              end else begin
                bit_idx_d = bit_idx_d + 5'd1;
                phase_d   = PH_BIT_LOW;
                wait_d    = {2'b00, cfg_i.bit_low_limit};
              end
            end
          end
          default: begin
            done    = 1'b1;
            phase_d = PH_IDLE;
            if (edge_fall) begin
              phase_d   = PH_CONFIRM;
              wait_d    = 10'd0;
              high_d    = 6'd0;
              bit_idx_d = 5'd0;
            end
          end
        endcase
      end
    end
  end

  assign frame_o = frame_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      wait_q       <= 10'd0;
      high_q       <= 6'd0;
      bit_idx_q    <= 5'd0;
      frame_q      <= 32'd0;
      last_level_q <= 1'b1;
    end else if (step_i) begin
      phase_q      <= phase_d;
      wait_q       <= wait_d;
      high_q       <= high_d;
      bit_idx_q    <= bit_idx_d;
      frame_q      <= frame_d;
      last_level_q <= level_i;
    end
  end

endmodule

`default_nettype wire
